// ----- hw/rtl/dice_sum_rejection_sampler_macros.svh -----
// assertion macros shared by the dice sum sampler rtl
// expects clk and rst_n in the scope of each use
`ifndef DICE_SUM_REJECTION_SAMPLER_MACROS_SVH
`define DICE_SUM_REJECTION_SAMPLER_MACROS_SVH

// same-cycle implication
`define DSRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsrs check failed");

// next-cycle implication
`define DSRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsrs check failed");

`endif

// ----- hw/rtl/dsrs_pkg.sv -----
// types, constants and face arithmetic for the dice sum sampler
// no dependencies
package dsrs_pkg;

  localparam int DICE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int MOD_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;
  localparam int FACE_W  = 7;

  localparam int MAX_DICE = 255;
  localparam int LEFT_W   = $clog2(MAX_DICE + 1);
  localparam int CNT_W    = (LEFT_W > DICE_W) ? LEFT_W : DICE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_BYTE    = 1'b1;

  localparam logic [KIND_W-1:0] KIND_D4   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_D6   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_D8   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_D10  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_D20  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_D100 = 3'd5;

  localparam logic [BYTE_W-1:0] REJ_D6   = 8'd252;
  localparam logic [BYTE_W-1:0] REJ_D10  = 8'd250;
  localparam logic [BYTE_W-1:0] REJ_D20  = 8'd240;
  localparam logic [BYTE_W-1:0] REJ_D100 = 8'd200;

  typedef logic [1:0] op_code_t;
  localparam op_code_t OP_LOAD      = 2'd0;
  localparam op_code_t OP_LOAD_EMIT = 2'd1;
  localparam op_code_t OP_ADD       = 2'd2;
  localparam op_code_t OP_ADD_EMIT  = 2'd3;

  typedef struct packed {
    op_code_t            op;
    logic [FACE_W-1:0]   face;
    logic                subtract;
    logic [MOD_W-1:0]    modifier;
  } op_entry_t;

  typedef struct packed {
    logic      valid;
    op_entry_t entry;
  } op_push_t;

  // remainder by a small constant via reciprocal and one correction
  function automatic logic [BYTE_W-1:0] rem_const(input logic [BYTE_W-1:0] b,
                                                  input logic [6:0] d,
                                                  input logic [15:0] m);
    logic [23:0] prod;
    logic [7:0]  q;
    logic [15:0] qd;
    logic [8:0]  r;
    prod = 24'(b) * 24'(m);
    q    = prod[23:16];
    qd   = 16'(q) * 16'(d);
    r    = 9'(16'(b) - qd);
    if (r >= 9'(d)) begin
      r = r - 9'(d);
    end
    return r[BYTE_W-1:0];
  endfunction

  function automatic logic [FACE_W-1:0] roll_face(input logic [KIND_W-1:0] kind,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    case (kind)
      KIND_D4:   r = {6'b0, b[1:0]};
      KIND_D6:   r = rem_const(b, 7'd6, 16'd10922);
      KIND_D8:   r = {5'b0, b[2:0]};
      KIND_D10:  r = rem_const(b, 7'd10, 16'd6553);
      KIND_D20:  r = rem_const(b, 7'd20, 16'd3276);
      KIND_D100: r = rem_const(b, 7'd100, 16'd655);
      default:   r = '0;
    endcase
    return FACE_W'(r + 8'd1);
  endfunction

  function automatic logic is_rejected(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] b);
    logic rej;
    case (kind)
      KIND_D6:   rej = (b >= REJ_D6);
      KIND_D10:  rej = (b >= REJ_D10);
      KIND_D20:  rej = (b >= REJ_D20);
      KIND_D100: rej = (b >= REJ_D100);
      default:   rej = 1'b0;
    endcase
    return rej;
  endfunction

endpackage

// ----- hw/rtl/dsrs_if.sv -----
// valid/ready channel interfaces for the dice sum sampler
// depends on dsrs_pkg
interface dsrs_in_if import dsrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DICE_W-1:0] dice_count;
  logic [KIND_W-1:0] die_kind;
  logic              subtract;
  logic [MOD_W-1:0]  modifier;
  logic [BYTE_W-1:0] entropy_byte;

  modport source (output valid, cmd, dice_count, die_kind, subtract, modifier,
                  entropy_byte, input ready);
  modport sink (input valid, cmd, dice_count, die_kind, subtract, modifier,
                entropy_byte, output ready);
endinterface

interface dsrs_out_if import dsrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total;

  modport source (output valid, total, input ready);
  modport sink (input valid, total, output ready);
endinterface

// ----- hw/rtl/dice_sum_rejection_sampler.sv -----
// dice sum sampler: rolls n dice from a random byte stream
// input beats carry a roll request (cmd 0) or one entropy byte (cmd 1);
// each result beat carries the dice sum with the modifier added or subtracted
// mod 2^32. a request while a roll is open, a request with an unknown die
// kind and a byte while no roll is open are dropped. bytes at or above the
// die's rejection threshold are dropped. a request for zero dice yields
// its result right away.
// throughput: one input beat per cycle while the queue is not full; the front
// classifies and computes the face value in the accepting cycle, the back
// accumulates one queued operation per cycle unless a result-producing entry
// waits on a stalled receiver. the last byte (or the zero-dice request) is
// queued first; the result beat is registered when the back pops its entry.
// a four-entry queue parts front and back: a stalled receiver holds the
// result register, and the back stops at the next result-producing entry;
// the front keeps taking beats until the queue fills, then in ready drops.
// reset (synchronous, active low) empties the queue and the result register
// and leaves no roll open.
// depends on dsrs_pkg, dsrs_if, dsrs_front, dsrs_queue, dsrs_back

module dice_sum_rejection_sampler import dsrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dsrs_in_if.sink    in_ch,
  dsrs_out_if.source out_ch
);

  op_push_t  push;
  op_entry_t head;
  logic      q_full, q_empty, pop;

  dsrs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  dsrs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  dsrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- hw/rtl/dsrs_front.sv -----
// front end: accepts beats, tracks request state, rejects bytes, computes faces
// depends on dsrs_pkg, dsrs_in_if and the macros header
`include "dice_sum_rejection_sampler_macros.svh"

module dsrs_front import dsrs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dsrs_in_if.sink       in_ch,
  input  logic          q_full,
  output op_push_t      push
);

  logic              busy_r, busy_nxt;
  logic [LEFT_W-1:0] dice_left_r, dice_left_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              accept;
  logic [CNT_W-1:0]  cnt_wide;
  logic [CNT_W-1:0]  cnt_sat;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_wide    = CNT_W'(in_ch.dice_count);
  assign cnt_sat     = (cnt_wide > CNT_W'(MAX_DICE)) ? CNT_W'(MAX_DICE) : cnt_wide;

  always_comb begin
    busy_nxt                = busy_r;
    dice_left_nxt           = dice_left_r;
    kind_nxt                = kind_r;
    push.valid              = 1'b0;
    push.entry.op           = OP_ADD;
    push.entry.face         = '0;
    push.entry.subtract     = in_ch.subtract;
    push.entry.modifier     = in_ch.modifier;
    if (accept) begin
      if (in_ch.cmd == CMD_REQUEST) begin
        if (!busy_r && in_ch.die_kind <= KIND_D100) begin
          push.valid = 1'b1;
          kind_nxt   = in_ch.die_kind;
          if (cnt_sat == '0) begin
            push.entry.op = OP_LOAD_EMIT;
          end else begin
            push.entry.op = OP_LOAD;
            busy_nxt      = 1'b1;
            dice_left_nxt = LEFT_W'(cnt_sat);
          end
        end
      end else if (busy_r && !is_rejected(kind_r, in_ch.entropy_byte)) begin
        push.valid      = 1'b1;
        push.entry.face = roll_face(kind_r, in_ch.entropy_byte);
        dice_left_nxt   = dice_left_r - 1'b1;
        if (dice_left_r == LEFT_W'(1)) begin
          push.entry.op = OP_ADD_EMIT;
          busy_nxt      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      dice_left_r <= '0;
      kind_r      <= KIND_D4;
    end else begin
      busy_r      <= busy_nxt;
      dice_left_r <= dice_left_nxt;
      kind_r      <= kind_nxt;
    end
  end

  `DSRS_ASSERT_IMPL(a_busy_has_dice, busy_r, dice_left_r != '0)
  `DSRS_ASSERT_NEXT(a_last_die_idles, push.valid && push.entry.op == OP_ADD_EMIT, !busy_r)

endmodule

// ----- hw/rtl/dsrs_queue.sv -----
// short operation queue between front and back
// depends on dsrs_pkg and the macros header
`include "dice_sum_rejection_sampler_macros.svh"

module dsrs_queue import dsrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  op_push_t  push,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output op_entry_t head
);

  op_entry_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign full   = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `DSRS_ASSERT_IMPL(a_no_overflow, push.valid, !full)
  `DSRS_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ----- hw/rtl/dsrs_back.sv -----
// back end: accumulates faces, applies the modifier, holds the result beat
// depends on dsrs_pkg, dsrs_out_if and the macros header
`include "dice_sum_rejection_sampler_macros.svh"

module dsrs_back import dsrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  op_entry_t  head,
  output logic       pop,
  dsrs_out_if.source out_ch
);

  logic [TOTAL_W-1:0] acc_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r, out_valid_nxt;
  logic               is_load, is_emit;
  logic [TOTAL_W-1:0] init_sum, base, sum;

  assign is_load  = (head.op == OP_LOAD) || (head.op == OP_LOAD_EMIT);
  assign is_emit  = (head.op == OP_LOAD_EMIT) || (head.op == OP_ADD_EMIT);
  assign init_sum = head.subtract ? (TOTAL_W'(0) - TOTAL_W'(head.modifier))
                                  : TOTAL_W'(head.modifier);
  assign base     = is_load ? init_sum : acc_r;
  assign sum      = base + TOTAL_W'(head.face);

  assign pop = !q_empty && (!is_emit || !out_valid_r || out_ch.ready);

  assign out_ch.valid = out_valid_r;
  assign out_ch.total = total_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && is_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_r <= sum;
    end
    if (pop && is_emit) begin
      total_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  `DSRS_ASSERT_IMPL(a_no_result_overwrite, pop && is_emit, !out_valid_r || out_ch.ready)

endmodule

// ----- sim/tb_dice_sum_rejection_sampler.sv -----
`timescale 1ns / 100ps
// testbench for dice_sum_rejection_sampler: directed and random request/byte beats,
// totals predicted by a scoreboard class and checked in order on the result channel
// depends on dsrs_pkg, dsrs_if and the sampler rtl
module tb_dice_sum_rejection_sampler;
  import dsrs_pkg::*;

  localparam int ROLL_BEATS   = 1400;
  localparam int DRAIN_CYCLES = 20000;
  localparam int SETTLE       = 10;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct {
    bit              cmd;
    bit [DICE_W-1:0] dice_count;
    bit [KIND_W-1:0] die_kind;
    bit              subtract;
    bit [MOD_W-1:0]  modifier;
    bit [BYTE_W-1:0] entropy_byte;
  } roll_beat_t;

  class roll_tracker;
    bit                rolling;
    int                dice_left;
    bit [TOTAL_W-1:0]  dice_sum;
    bit [KIND_W-1:0]   held_kind;
    bit                held_subtract;
    bit [MOD_W-1:0]    held_modifier;
    bit [TOTAL_W-1:0]  pending_totals[$];
    int                mismatches;

    function new();
      rolling = 1'b0;
      dice_left = 0;
      dice_sum = '0;
      held_kind = KIND_D4;
      held_subtract = 1'b0;
      held_modifier = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function int faces(bit [KIND_W-1:0] kind);
      case (kind)
        KIND_D4:   return 4;
        KIND_D6:   return 6;
        KIND_D8:   return 8;
        KIND_D10:  return 10;
        KIND_D20:  return 20;
        default:   return 100;
      endcase
    endfunction

    function bit byte_dropped(bit [KIND_W-1:0] kind, bit [BYTE_W-1:0] b);
      case (kind)
        KIND_D6:   return b >= REJ_D6;
        KIND_D10:  return b >= REJ_D10;
        KIND_D20:  return b >= REJ_D20;
        KIND_D100: return b >= REJ_D100;
        default:   return 1'b0;
      endcase
    endfunction

    function bit [TOTAL_W-1:0] with_modifier(bit [TOTAL_W-1:0] s);
      if (held_subtract) return s - TOTAL_W'(held_modifier);
      return s + TOTAL_W'(held_modifier);
    endfunction

    // returns 1 unless the beat is dropped as out of place or for an unknown die kind
    function bit note_beat(roll_beat_t b);
      if (b.cmd == CMD_REQUEST) begin
        if (rolling || b.die_kind > KIND_D100) return 1'b0;
        held_kind = b.die_kind;
        held_subtract = b.subtract;
        held_modifier = b.modifier;
        dice_sum = '0;
        dice_left = (b.dice_count > MAX_DICE) ? MAX_DICE : int'(b.dice_count);
        if (dice_left == 0) pending_totals.push_back(with_modifier('0));
        else rolling = 1'b1;
        return 1'b1;
      end
      if (!rolling) return 1'b0;
      if (byte_dropped(held_kind, b.entropy_byte)) return 1'b1;
      dice_sum = dice_sum + TOTAL_W'(int'(b.entropy_byte) % faces(held_kind)) + 1;
      dice_left--;
      if (dice_left == 0) begin
        rolling = 1'b0;
        pending_totals.push_back(with_modifier(dice_sum));
      end
      return 1'b1;
    endfunction

    task check_total(bit [TOTAL_W-1:0] total);
      bit [TOTAL_W-1:0] want;
      if (pending_totals.size() == 0) begin
        report_mismatch($sformatf("unexpected total %0h", total));
      end else begin
        want = pending_totals.pop_front();
        if (total !== want)
          report_mismatch($sformatf("total got %0h expected %0h", total, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   rolled_beats;
  roll_tracker sb;

  dsrs_in_if  in_ch();
  dsrs_out_if out_ch();

  dice_sum_rejection_sampler u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_total(out_ch.total);
    end
  end

  function automatic roll_beat_t beat_of(bit cmd, bit [DICE_W-1:0] count,
                                         bit [KIND_W-1:0] kind, bit sub,
                                         bit [MOD_W-1:0] modifier,
                                         bit [BYTE_W-1:0] entropy);
    roll_beat_t b;
    b.cmd = cmd;
    b.dice_count = count;
    b.die_kind = kind;
    b.subtract = sub;
    b.modifier = modifier;
    b.entropy_byte = entropy;
    return b;
  endfunction

  // mostly well-formed rolls, some stray bytes and requests while busy
  function automatic roll_beat_t random_beat(bit rolling);
    roll_beat_t b;
    int pick;
    int size_pick;
    b = beat_of(CMD_BYTE, DICE_W'($urandom), KIND_W'($urandom), 1'($urandom),
                MOD_W'($urandom), BYTE_W'($urandom));
    pick = $urandom_range(99);
    if (!rolling) begin
      if (pick < 85) begin
        b.cmd = CMD_REQUEST;
        b.die_kind = KIND_W'($urandom_range(5));
        size_pick = $urandom_range(999);
        if (size_pick < 4) b.dice_count = DICE_W'(MAX_DICE);
        else if (size_pick < 14) b.dice_count = DICE_W'($urandom);
        else if (size_pick < 160) b.dice_count = DICE_W'($urandom_range(40, 7));
        else b.dice_count = DICE_W'($urandom_range(6));
      end else if (pick >= 93) begin
        b.cmd = CMD_REQUEST;
      end
    end else if (pick >= 93) begin
      b.cmd = CMD_REQUEST;
    end
    return b;
  endfunction

  task automatic send_beat(roll_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= b.cmd;
    in_ch.dice_count   <= b.dice_count;
    in_ch.die_kind     <= b.die_kind;
    in_ch.subtract     <= b.subtract;
    in_ch.modifier     <= b.modifier;
    in_ch.entropy_byte <= b.entropy_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (sb.note_beat(b)) rolled_beats++;
    @(negedge clk);
  endtask

  task automatic wait_drained(int limit);
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_totals.size() != 0 && n < limit) begin
      @(negedge clk);
      n++;
    end
  endtask

  initial begin
    roll_beat_t nb;
    int ph;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 59;
    rolled_beats = 0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_REQUEST;
    in_ch.dice_count = '0;
    in_ch.die_kind = KIND_D4;
    in_ch.subtract = 1'b0;
    in_ch.modifier = '0;
    in_ch.entropy_byte = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 59;
        recv_idle_pct = 36;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0) begin
        // zero dice: largest added modifier, a subtraction that wraps, a zero modifier
        send_beat(beat_of(CMD_REQUEST, 8'd0, KIND_D4, 1'b0, 16'hFFFF, 8'h00));
        send_beat(beat_of(CMD_REQUEST, 8'd0, KIND_D100, 1'b1, 16'h0001, 8'hFF));
        send_beat(beat_of(CMD_REQUEST, 8'd0, KIND_D20, 1'b1, 16'h0000, 8'h00));
        // stray byte and unknown kinds
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'hFF));
        send_beat(beat_of(CMD_REQUEST, 8'd3, KIND_UNUSED_LO, 1'b0, 16'h1234, 8'h00));
        send_beat(beat_of(CMD_REQUEST, 8'd255, KIND_UNUSED_HI, 1'b1, 16'hFFFF, 8'hFF));
        // d6 with rejects and a request while busy, then one roll of each other kind
        send_beat(beat_of(CMD_REQUEST, 8'd2, KIND_D6, 1'b0, 16'h8000, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd252));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd255));
        send_beat(beat_of(CMD_REQUEST, 8'd0, KIND_D4, 1'b1, 16'hFFFF, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd251));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd0));
        send_beat(beat_of(CMD_REQUEST, 8'd1, KIND_D10, 1'b1, 16'hFFFF, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd250));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd249));
        send_beat(beat_of(CMD_REQUEST, 8'd1, KIND_D20, 1'b0, 16'h00FF, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd240));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd239));
        send_beat(beat_of(CMD_REQUEST, 8'd2, KIND_D100, 1'b1, 16'h0002, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd200));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd199));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd0));
        send_beat(beat_of(CMD_REQUEST, 8'd1, KIND_D8, 1'b0, 16'h0000, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd255));
        send_beat(beat_of(CMD_REQUEST, 8'd1, KIND_D4, 1'b1, 16'h0005, 8'h00));
        send_beat(beat_of(CMD_BYTE, 8'd0, KIND_D4, 1'b0, 16'h0000, 8'd255));
      end
      while (rolled_beats < (ph + 1) * ROLL_BEATS / 3) begin
        nb = random_beat(sb.rolling);
        send_beat(nb);
      end
      // hold off until every total of the phase is out or the drain limit runs out
      wait_drained(DRAIN_CYCLES);
    end

    repeat (SETTLE) @(negedge clk);
    if (sb.pending_totals.size() != 0)
      sb.report_mismatch($sformatf("%0d totals never arrived", sb.pending_totals.size()));
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- dice_sum_rejection_sampler.f -----
+incdir+hw/rtl
hw/rtl/dsrs_pkg.sv
hw/rtl/dsrs_if.sv
hw/rtl/dsrs_front.sv
hw/rtl/dsrs_queue.sv
hw/rtl/dsrs_back.sv
hw/rtl/dice_sum_rejection_sampler.sv
sim/tb_dice_sum_rejection_sampler.sv
